FILE: rtl/core/bhpq_pkg.sv
`default_nettype none

package bhpq_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 32;
    localparam int IO_KEY_W      = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 7;
    localparam int MAX_KEY_W     = 64;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // start of a sift token, broadcast by the controller to every level
    typedef struct packed {
        logic vld;
        logic up;
    } tok_ctl_t;

    // true when key a strictly beats key b under the current order
    function automatic logic beats(input logic signed [MAX_KEY_W-1:0] a,
                                   input logic signed [MAX_KEY_W-1:0] b,
                                   input logic max_order);
        logic res;
        res = max_order ? (a > b) : (a < b);
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bhpq_cell.sv
`default_nettype none

module bhpq_cell import bhpq_pkg::*; #(
    parameter int LVL       = 0,
    parameter int LEVELS    = 7,
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        max_order,
    input  wire logic [LEVELS-1:0]           count,
    // token start from the controller
    input  wire tok_ctl_t                    st_ctl,
    input  wire logic [LEVELS-1:0]           st_idx,
    input  wire logic signed [KEY_WIDTH-1:0] st_key,
    // controller read of one entry
    input  wire logic                        rd_vld,
    input  wire logic [LEVELS-1:0]           rd_idx,
    output logic signed [KEY_WIDTH-1:0]      ctl_key,
    // token arriving from the parent level, moving down
    input  wire logic                        in_dn_vld,
    input  wire logic signed [KEY_WIDTH-1:0] in_dn_key,
    input  wire logic [LEVELS-2:0]           in_dn_off,
    // token arriving from the child level, moving up
    input  wire logic                        in_up_vld,
    input  wire logic signed [KEY_WIDTH-1:0] in_up_key,
    input  wire logic [LEVELS-2:0]           in_up_off,
    // token leaving this level
    output logic                             out_dn_vld,
    output logic [LEVELS-2:0]                out_dn_off,
    output logic                             out_up_vld,
    output logic [LEVELS-2:0]                out_up_off,
    output logic signed [KEY_WIDTH-1:0]      out_key,
    // read requests from neighbors into this level
    input  wire logic                        rq_par_vld,
    input  wire logic [LEVELS-2:0]           rq_par_row,
    input  wire logic                        rq_chd_vld,
    input  wire logic [LEVELS-2:0]           rq_chd_row,
    // read requests from this level into neighbors
    output logic                             rq_dn_vld,
    output logic [LEVELS-2:0]                rq_dn_row,
    output logic                             rq_up_vld,
    output logic [LEVELS-2:0]                rq_up_row,
    // read data
    input  wire logic signed [KEY_WIDTH-1:0] par_rd_l,
    input  wire logic signed [KEY_WIDTH-1:0] par_rd_r,
    input  wire logic signed [KEY_WIDTH-1:0] chd_rd_l,
    input  wire logic signed [KEY_WIDTH-1:0] chd_rd_r,
    output logic signed [KEY_WIDTH-1:0]      rd_l,
    output logic signed [KEY_WIDTH-1:0]      rd_r,
    output logic                             done
);

    localparam int CW      = LEVELS;
    localparam int OW      = LEVELS - 1;
    localparam int IW      = LEVELS + 1;
    localparam int ENT_LVL = 1 << LVL;
    localparam int ENT_CAP = CAPACITY + 1 - ENT_LVL;
    localparam int ENTRIES = (ENT_LVL < ENT_CAP) ? ENT_LVL : ENT_CAP;
    localparam int ROWS    = (ENTRIES + 1) / 2;
    localparam int AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH   = 1 << AW;

    localparam logic [OW-1:0] OFF_MASK   = OW'((64'd1 << LVL) - 64'd1);
    localparam logic [IW-1:0] CHILD_BASE = IW'(64'd1 << (LVL + 1));
    localparam logic [CW-1:0] LVL_ONE    = CW'(1);
    localparam logic          IS_ROOT    = (LVL == 0);

    // sibling pairs share a row: left entries at even offsets, right at odd
    logic signed [KEY_WIDTH-1:0] mem_l [DEPTH];
    logic signed [KEY_WIDTH-1:0] mem_r [DEPTH];

    logic signed [KEY_WIDTH-1:0] rd_l_reg;
    logic signed [KEY_WIDTH-1:0] rd_r_reg;
    logic                        b_hit_reg;
    logic                        b_side_reg;

    logic                        tok_vld_reg;
    logic                        tok_up_reg;
    logic                        tok_ph_reg;
    logic signed [KEY_WIDTH-1:0] tok_key_reg;
    logic [OW-1:0]               tok_off_reg;

    logic                        b_hit;
    logic [OW-1:0]               b_off;
    logic [OW-1:0]               rd_row;
    logic [AW-1:0]               rd_addr;
    logic                        st_hit;

    logic [IW-1:0]               li;
    logic [IW-1:0]               ri;
    logic [IW-1:0]               cnt;
    logic                        kids;
    logic                        two;
    logic signed [KEY_WIDTH-1:0] cv;
    logic                        cs;
    logic                        move_dn;
    logic [OW-1:0]               pof;
    logic signed [KEY_WIDTH-1:0] pv;
    logic                        move_up;
    logic                        fin;

    logic                        wr_en;
    logic signed [KEY_WIDTH-1:0] wr_key;
    logic [OW-1:0]               wr_row;
    logic [AW-1:0]               wr_addr;

    assign st_hit = st_ctl.vld && ((st_idx >> LVL) == LVL_ONE);
    assign b_hit  = rd_vld && ((rd_idx >> LVL) == LVL_ONE);
    assign b_off  = OW'(rd_idx) & OFF_MASK;

    always_comb begin
        if (rq_par_vld) begin
            rd_row = rq_par_row;
        end else if (rq_chd_vld) begin
            rd_row = rq_chd_row;
        end else if (b_hit) begin
            rd_row = b_off >> 1;
        end else begin
            rd_row = '0;
        end
    end

    assign rd_addr = rd_row[AW-1:0];

    always_ff @(posedge aclk) begin
        rd_l_reg <= mem_l[rd_addr];
        rd_r_reg <= mem_r[rd_addr];
        if (wr_en) begin
            if (tok_off_reg[0]) begin
                mem_r[wr_addr] <= wr_key;
            end else begin
                mem_l[wr_addr] <= wr_key;
            end
        end
    end

    assign rd_l    = rd_l_reg;
    assign rd_r    = rd_r_reg;
    assign ctl_key = b_hit_reg ? (b_side_reg ? rd_r_reg : rd_l_reg) : '0;

    // child selection for a downward step
    assign li   = CHILD_BASE | (IW'(tok_off_reg) << 1);
    assign ri   = li | IW'(1);
    assign cnt  = IW'(count);
    assign kids = (li <= cnt);
    assign two  = (ri <= cnt);

    always_comb begin
        if (!two) begin
            cv = chd_rd_l;
            cs = 1'b0;
        end else if (beats(MAX_KEY_W'(chd_rd_l), MAX_KEY_W'(chd_rd_r), max_order)) begin
            cv = chd_rd_l;
            cs = 1'b0;
        end else begin
            cv = chd_rd_r;
            cs = 1'b1;
        end
    end

    assign move_dn = kids && beats(MAX_KEY_W'(cv), MAX_KEY_W'(tok_key_reg), max_order);

    // parent for an upward step
    assign pof     = tok_off_reg >> 1;
    assign pv      = pof[0] ? par_rd_r : par_rd_l;
    assign move_up = !IS_ROOT && beats(MAX_KEY_W'(tok_key_reg), MAX_KEY_W'(pv), max_order);

    assign fin = tok_vld_reg && (tok_ph_reg || (tok_up_reg && IS_ROOT));

    assign rq_dn_vld = tok_vld_reg && !tok_ph_reg && !tok_up_reg;
    assign rq_dn_row = tok_off_reg;
    assign rq_up_vld = tok_vld_reg && !tok_ph_reg && tok_up_reg && !IS_ROOT;
    assign rq_up_row = tok_off_reg >> 2;

    assign out_key    = tok_key_reg;
    assign out_dn_off = (tok_off_reg << 1) | OW'(cs);
    assign out_up_off = pof;
    assign wr_row     = tok_off_reg >> 1;
    assign wr_addr    = wr_row[AW-1:0];

    always_comb begin
        wr_en      = 1'b0;
        wr_key     = tok_key_reg;
        out_dn_vld = 1'b0;
        out_up_vld = 1'b0;
        done       = 1'b0;
        if (fin) begin
            wr_en = 1'b1;
            if (tok_up_reg) begin
                // move the parent into the hole, or drop the key here
                wr_key     = move_up ? pv : tok_key_reg;
                out_up_vld = move_up;
                done       = !move_up;
            end else begin
                wr_key     = move_dn ? cv : tok_key_reg;
                out_dn_vld = move_dn;
                done       = !move_dn;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_vld_reg <= 1'b0;
            tok_up_reg  <= 1'b0;
            tok_ph_reg  <= 1'b0;
            b_hit_reg   <= 1'b0;
        end else begin
            b_hit_reg  <= b_hit;
            b_side_reg <= b_off[0];
            if (st_hit) begin
                tok_vld_reg <= 1'b1;
                tok_up_reg  <= st_ctl.up;
                tok_ph_reg  <= 1'b0;
                tok_key_reg <= st_key;
                tok_off_reg <= OW'(st_idx) & OFF_MASK;
            end else if (in_dn_vld) begin
                tok_vld_reg <= 1'b1;
                tok_up_reg  <= 1'b0;
                tok_ph_reg  <= 1'b0;
                tok_key_reg <= in_dn_key;
                tok_off_reg <= in_dn_off;
            end else if (in_up_vld) begin
                tok_vld_reg <= 1'b1;
                tok_up_reg  <= 1'b1;
                tok_ph_reg  <= 1'b0;
                tok_key_reg <= in_up_key;
                tok_off_reg <= in_up_off;
            end else if (fin) begin
                tok_vld_reg <= 1'b0;
                tok_ph_reg  <= 1'b0;
            end else if (tok_vld_reg) begin
                // neighbor read issued, wait for its data
                tok_ph_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bhpq_ctrl.sv
`default_nettype none

module bhpq_ctrl import bhpq_pkg::*; #(
    parameter int LEVELS    = 7,
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    input  wire logic                        cfg_max_order,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [OP_W-1:0]             s_op,
    input  wire logic signed [IO_KEY_W-1:0]  s_key_in,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [IO_KEY_W-1:0]       m_key_out,
    output logic [STATUS_W-1:0]              m_status,
    output logic [COUNT_W-1:0]               m_count,
    output logic                             max_order,
    output logic [LEVELS-1:0]                count,
    output tok_ctl_t                         st_ctl,
    output logic [LEVELS-1:0]                st_idx,
    output logic signed [KEY_WIDTH-1:0]      st_key,
    output logic                             rd_vld,
    output logic [LEVELS-1:0]                rd_idx,
    input  wire logic signed [KEY_WIDTH-1:0] root_key,
    input  wire logic signed [KEY_WIDTH-1:0] last_keys [LEVELS],
    input  wire logic [LEVELS-1:0]           done_vec
);

    localparam int CW = LEVELS;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_SIFT,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [CW-1:0]               count_reg;
    logic                        max_order_reg;
    logic [OP_W-1:0]             op_reg;
    logic signed [KEY_WIDTH-1:0] res_key_reg;
    logic [STATUS_W-1:0]         res_status_reg;
    logic                        m_valid_reg;
    logic signed [IO_KEY_W-1:0]  m_key_reg;
    logic [STATUS_W-1:0]         m_status_reg;
    logic [COUNT_W-1:0]          m_count_reg;

    logic                        push_ok;
    logic signed [KEY_WIDTH-1:0] last_key;

    assign push_ok = (count_reg < CAP_CNT);

    // only the level that holds the last entry returns its key; the others return zero
    always_comb begin
        last_key = '0;
        for (int i = 0; i < LEVELS; i++) begin
            last_key = last_key | last_keys[i];
        end
    end

    always_comb begin
        st_ctl.vld = 1'b0;
        st_ctl.up  = 1'b0;
        st_idx     = CNT_ONE;
        st_key     = last_key;
        if (state_reg == S_IDLE) begin
            st_ctl.vld = s_valid && (s_op == OP_PUSH) && push_ok;
            st_ctl.up  = 1'b1;
            st_idx     = count_reg + CNT_ONE;
            st_key     = KEY_WIDTH'(s_key_in);
        end else if (state_reg == S_LOAD) begin
            st_ctl.vld = (op_reg == OP_POP) && (count_reg > CNT_ONE);
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign rd_vld    = (state_reg == S_READ);
    assign rd_idx    = count_reg;
    assign count     = count_reg;
    assign max_order = max_order_reg;
    assign m_valid   = m_valid_reg;
    assign m_key_out = m_key_reg;
    assign m_status  = m_status_reg;
    assign m_count   = m_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            max_order_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                max_order_reg <= cfg_max_order;
            end
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg      <= s_op;
                        res_key_reg <= '0;
                        unique case (s_op) inside
                            OP_PUSH: begin
                                if (push_ok) begin
                                    count_reg      <= count_reg + CNT_ONE;
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_SIFT;
                                end else begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_DONE;
                                end
                            end
                            OP_POP, OP_PEEK: begin
                                if (count_reg == '0) begin
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_DONE;
                                end else begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_READ;
                                end
                            end
                            default: begin
                                res_status_reg <= ST_OK;
                                state_reg      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    state_reg <= S_LOAD;
                end
                S_LOAD: begin
                    res_key_reg <= root_key;
                    if (op_reg == OP_POP) begin
                        count_reg <= count_reg - CNT_ONE;
                        state_reg <= (count_reg > CNT_ONE) ? S_SIFT : S_DONE;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_SIFT: begin
                    if (|done_vec) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold the result until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_key_reg    <= IO_KEY_W'(res_key_reg);
                        m_status_reg <= res_status_reg;
                        m_count_reg  <= COUNT_W'(count_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/binary_heap_priority_queue_top.sv
// Channel  Direction  Handshake            Payload
// cfg      in         cfg_valid/cfg_ready  cfg_max_order (0 min-heap, 1 max-heap)
// s        in         s_valid/s_ready      s_op, s_key_in
// m        out        m_valid/m_ready      m_key_out, m_status, m_count
//
// One item at a time: a push sifts its key up from the new last slot toward the root; a pop
// moves the last key to the root and sifts it down; a peek or a pop of the last key reads
// the root without a sift; empty, full and op 3 go straight to the result.
// A sift step reads the neighbor level, then decides and writes; s_ready returns once the
// result is loaded into the output register.
// Reset is synchronous, active low, no clearing pass; a result waits in an output register
// while the next item runs, and the next result holds until m_ready frees it.
`default_nettype none

module binary_heap_priority_queue_top import bhpq_pkg::*; #(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic                       cfg_max_order,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [OP_W-1:0]            s_op,
    input  wire logic signed [IO_KEY_W-1:0] s_key_in,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [IO_KEY_W-1:0]      m_key_out,
    output logic [STATUS_W-1:0]             m_status,
    output logic [COUNT_W-1:0]              m_count
);

    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam int OW     = LEVELS - 1;

    logic                        max_order;
    logic [LEVELS-1:0]           count;
    tok_ctl_t                    st_ctl;
    logic [LEVELS-1:0]           st_idx;
    logic signed [KEY_WIDTH-1:0] st_key;
    logic                        rd_vld;
    logic [LEVELS-1:0]           rd_idx;

    logic [LEVELS-1:0]           dn_vld;
    logic [LEVELS-1:0]           up_vld;
    logic [LEVELS-1:0]           rqd_vld;
    logic [LEVELS-1:0]           rqu_vld;
    logic [LEVELS-1:0]           done_vec;
    logic [OW-1:0]               dn_off  [LEVELS];
    logic [OW-1:0]               up_off  [LEVELS];
    logic [OW-1:0]               rqd_row [LEVELS];
    logic [OW-1:0]               rqu_row [LEVELS];
    logic signed [KEY_WIDTH-1:0] tkey    [LEVELS];
    logic signed [KEY_WIDTH-1:0] rdl     [LEVELS];
    logic signed [KEY_WIDTH-1:0] rdr     [LEVELS];
    logic signed [KEY_WIDTH-1:0] ckey    [LEVELS];

    assign cfg_ready = 1'b1;

    bhpq_ctrl #(
        .LEVELS    (LEVELS),
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_max_order (cfg_max_order),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key_in      (s_key_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_key_out     (m_key_out),
        .m_status      (m_status),
        .m_count       (m_count),
        .max_order     (max_order),
        .count         (count),
        .st_ctl        (st_ctl),
        .st_idx        (st_idx),
        .st_key        (st_key),
        .rd_vld        (rd_vld),
        .rd_idx        (rd_idx),
        .root_key      (rdl[0]),
        .last_keys     (ckey),
        .done_vec      (done_vec)
    );

    for (genvar g = 0; g < LEVELS; g++) begin : g_lvl
        logic                        in_dn_vld;
        logic signed [KEY_WIDTH-1:0] in_dn_key;
        logic [OW-1:0]               in_dn_off;
        logic                        rq_par_vld;
        logic [OW-1:0]               rq_par_row;
        logic signed [KEY_WIDTH-1:0] par_rd_l;
        logic signed [KEY_WIDTH-1:0] par_rd_r;
        logic                        in_up_vld;
        logic signed [KEY_WIDTH-1:0] in_up_key;
        logic [OW-1:0]               in_up_off;
        logic                        rq_chd_vld;
        logic [OW-1:0]               rq_chd_row;
        logic signed [KEY_WIDTH-1:0] chd_rd_l;
        logic signed [KEY_WIDTH-1:0] chd_rd_r;

        if (g == 0) begin : g_top_edge
            assign in_dn_vld  = 1'b0;
            assign in_dn_key  = '0;
            assign in_dn_off  = '0;
            assign rq_par_vld = 1'b0;
            assign rq_par_row = '0;
            assign par_rd_l   = '0;
            assign par_rd_r   = '0;
        end else begin : g_top_link
            assign in_dn_vld  = dn_vld[g-1];
            assign in_dn_key  = tkey[g-1];
            assign in_dn_off  = dn_off[g-1];
            assign rq_par_vld = rqd_vld[g-1];
            assign rq_par_row = rqd_row[g-1];
            assign par_rd_l   = rdl[g-1];
            assign par_rd_r   = rdr[g-1];
        end

        if (g == LEVELS - 1) begin : g_bot_edge
            assign in_up_vld  = 1'b0;
            assign in_up_key  = '0;
            assign in_up_off  = '0;
            assign rq_chd_vld = 1'b0;
            assign rq_chd_row = '0;
            assign chd_rd_l   = '0;
            assign chd_rd_r   = '0;
        end else begin : g_bot_link
            assign in_up_vld  = up_vld[g+1];
            assign in_up_key  = tkey[g+1];
            assign in_up_off  = up_off[g+1];
            assign rq_chd_vld = rqu_vld[g+1];
            assign rq_chd_row = rqu_row[g+1];
            assign chd_rd_l   = rdl[g+1];
            assign chd_rd_r   = rdr[g+1];
        end

        bhpq_cell #(
            .LVL       (g),
            .LEVELS    (LEVELS),
            .CAPACITY  (CAPACITY),
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .max_order  (max_order),
            .count      (count),
            .st_ctl     (st_ctl),
            .st_idx     (st_idx),
            .st_key     (st_key),
            .rd_vld     (rd_vld),
            .rd_idx     (rd_idx),
            .ctl_key    (ckey[g]),
            .in_dn_vld  (in_dn_vld),
            .in_dn_key  (in_dn_key),
            .in_dn_off  (in_dn_off),
            .in_up_vld  (in_up_vld),
            .in_up_key  (in_up_key),
            .in_up_off  (in_up_off),
            .out_dn_vld (dn_vld[g]),
            .out_dn_off (dn_off[g]),
            .out_up_vld (up_vld[g]),
            .out_up_off (up_off[g]),
            .out_key    (tkey[g]),
            .rq_par_vld (rq_par_vld),
            .rq_par_row (rq_par_row),
            .rq_chd_vld (rq_chd_vld),
            .rq_chd_row (rq_chd_row),
            .rq_dn_vld  (rqd_vld[g]),
            .rq_dn_row  (rqd_row[g]),
            .rq_up_vld  (rqu_vld[g]),
            .rq_up_row  (rqu_row[g]),
            .par_rd_l   (par_rd_l),
            .par_rd_r   (par_rd_r),
            .chd_rd_l   (chd_rd_l),
            .chd_rd_r   (chd_rd_r),
            .rd_l       (rdl[g]),
            .rd_r       (rdr[g]),
            .done       (done_vec[g])
        );
    end

endmodule

`default_nettype wire

FILE: rtl/core/bhpq_checker.sv
`default_nettype none

module bhpq_checker import bhpq_pkg::*; (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic signed [IO_KEY_W-1:0] m_key_out,
    input wire logic [STATUS_W-1:0]        m_status,
    input wire logic [COUNT_W-1:0]         m_count
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key_out) && $stable(m_status)
            && $stable(m_count))
        else $error("result changed while stalled");

    // one item in flight: ready drops after every transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |-> (m_count == '0) && (m_key_out == '0))
        else $error("empty result with nonzero key or count");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |-> (m_key_out == '0))
        else $error("full result with nonzero key");

endmodule

bind binary_heap_priority_queue_top bhpq_checker u_bhpq_checker (.*);

`default_nettype wire
